### src/asa_pkg.sv
// Shared types, constants and helpers of the atlas shelf allocator.
// Depends on nothing; every other file refers to it by scoped names.
package asa_pkg;

	// Page table geometry
	localparam int PAGES       = 16;
	localparam int PG_IDX_W    = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int MAX_DIM     = 4096;
	localparam int DEFAULT_DIM = 512;

	// Field widths
	localparam int DIM_W      = 13;
	localparam int SUM_W      = DIM_W + 2;
	localparam int MARGIN_W   = 8;
	localparam int USERS_W    = 16;
	localparam int CMD_W      = 3;
	localparam int STATUS_W   = 2;
	localparam int ID_W       = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [DIM_W-1:0] DIM_SAT = {DIM_W{1'b1}};

	// Command codes
	localparam logic [CMD_W-1:0] CMD_INSERT_ANY  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT_PAGE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_CREATE      = 3'd2;
	localparam logic [CMD_W-1:0] CMD_ADD_USER    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_REMOVE_USER = 3'd4;
	localparam logic [CMD_W-1:0] CMD_RESIZE      = 3'd5;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_PAGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_FIT   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_W  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_H  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 2'd2;

	typedef struct packed {
		logic               valid;
		logic               locked;
		logic [DIM_W-1:0]   w;
		logic [DIM_W-1:0]   h;
		logic [DIM_W-1:0]   cur_x;
		logic [DIM_W-1:0]   cur_y;
		logic [DIM_W-1:0]   shelf;
		logic [USERS_W-1:0] users;
	} entry_t;

	typedef struct packed {
		logic             fit;
		logic [DIM_W-1:0] pos_x;
		logic [DIM_W-1:0] pos_y;
		logic [DIM_W-1:0] cur_x;
		logic [DIM_W-1:0] shelf;
	} fit_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     page_id;
		logic [DIM_W-1:0]    pos_x;
		logic [DIM_W-1:0]    pos_y;
		logic [DIM_W-1:0]    pw;
		logic [DIM_W-1:0]    ph;
		logic [USERS_W-1:0]  users;
	} res_t;

	// Clamp a grown sum back to the stored cursor range.
	function automatic logic [DIM_W-1:0] sat_dim(input logic [SUM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = (v > SUM_W'(DIM_SAT)) ? DIM_SAT : v[DIM_W-1:0];
		return r;
	endfunction

endpackage

### src/asa_page_table.sv
// Page table: one entry per atlas page, one read port and one write port.
// Uses asa_pkg for the entry layout; only the valid bits are reset.
module asa_page_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [asa_pkg::PG_IDX_W-1:0]   rd_idx,
	output asa_pkg::entry_t                rd_entry,
	input  logic                           wr_en,
	input  logic [asa_pkg::PG_IDX_W-1:0]   wr_idx,
	input  asa_pkg::entry_t                wr_entry
);

	logic [asa_pkg::PAGES-1:0] valid_q;
	asa_pkg::entry_t           data_q [asa_pkg::PAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_idx] <= wr_entry.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			data_q[wr_idx] <= wr_entry;
		end
	end

	always_comb begin
		rd_entry       = data_q[rd_idx];
		rd_entry.valid = valid_q[rd_idx];
	end

endmodule

### src/asa_fit_unit.sv
// Shelf fit unit: tests one page against a rectangle and works out the placement.
// Uses asa_pkg types; shared by the first-fit scan and the placement step.
module asa_fit_unit (
	input  asa_pkg::entry_t                  entry,
	input  logic [asa_pkg::DIM_W-1:0]        rect_w,
	input  logic [asa_pkg::DIM_W-1:0]        rect_h,
	input  logic [asa_pkg::MARGIN_W-1:0]     margin,
	input  logic [asa_pkg::DIM_W-1:0]        max_w,
	input  logic [asa_pkg::DIM_W-1:0]        max_h,
	output asa_pkg::fit_t                    result
);

	localparam int SW = asa_pkg::SUM_W;

	logic [SW-1:0] m1, m2, need_h, need_w, run_x, bottom;
	logic          too_big, new_shelf;

	always_comb begin
		m1      = SW'(margin);
		m2      = m1 << 1;
		need_h  = SW'(entry.shelf) + SW'(rect_h) + m2;
		need_w  = SW'(rect_w) + m2;
		run_x   = SW'(entry.cur_x) + SW'(rect_w) + m2;
		too_big = (entry.w > max_w) || (entry.h > max_h);

		result.fit = !too_big && (SW'(entry.h) >= need_h) && (SW'(entry.w) >= need_w);

		// Open a new shelf when the row cannot take the rectangle.
		new_shelf = SW'(entry.w) < run_x;
		if (new_shelf) begin
			result.pos_x = asa_pkg::sat_dim(m1);
			result.pos_y = asa_pkg::sat_dim(SW'(entry.shelf) + m1);
			result.cur_x = asa_pkg::sat_dim(need_w);
			bottom       = need_h;
		end else begin
			result.pos_x = asa_pkg::sat_dim(SW'(entry.cur_x) + m1);
			result.pos_y = entry.cur_y;
			result.cur_x = asa_pkg::sat_dim(run_x);
			bottom       = SW'(entry.cur_y) + SW'(rect_h) + m1;
		end
		result.shelf = (bottom > SW'(entry.shelf)) ? asa_pkg::sat_dim(bottom) : entry.shelf;
	end

endmodule

### src/atlas_shelf_allocator.sv
// Sequence: page commands run an update step, then the done step; an unknown command goes
// straight to done; insert-any and create scan up to 16 page entries one per cycle, then
// run a place or open step and the done step, which queues the result once the output is free.
// Flow: one command at a time; stall stays high until the result is queued.
// Reset: arst_n clears all page valid bits, sets the size registers to 512 and the
// margin to 0; the block comes out of reset idle, ready to accept a beat.
// Top level: command sequencer, configuration registers and result register.
// Depends on asa_pkg, asa_page_table and asa_fit_unit.
module atlas_shelf_allocator (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic [asa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [asa_pkg::CFG_DATA_W-1:0]    cfg_data,
	// command channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [asa_pkg::CMD_W-1:0]         command,
	input  logic [asa_pkg::ID_W-1:0]          page_index,
	input  logic [asa_pkg::DIM_W-1:0]         rect_width,
	input  logic [asa_pkg::DIM_W-1:0]         rect_height,
	input  logic                              lock_page,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [asa_pkg::STATUS_W-1:0]      status,
	output logic [asa_pkg::ID_W-1:0]          page_id,
	output logic [asa_pkg::DIM_W-1:0]         pos_x,
	output logic [asa_pkg::DIM_W-1:0]         pos_y,
	output logic [asa_pkg::DIM_W-1:0]         page_width,
	output logic [asa_pkg::DIM_W-1:0]         page_height,
	output logic [asa_pkg::USERS_W-1:0]       user_count
);

	localparam int IW = asa_pkg::PG_IDX_W;
	localparam int DW = asa_pkg::DIM_W;
	localparam int UW = asa_pkg::USERS_W;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SCAN   = 6'b000010,
		S_UPDATE = 6'b000100,
		S_PLACE  = 6'b001000,
		S_OPEN   = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t state_q, state_n;

	// Configuration registers
	logic [DW-1:0]                max_w_q, max_h_q;
	logic [asa_pkg::MARGIN_W-1:0] margin_q;

	// Command held for the duration of its work
	logic [asa_pkg::CMD_W-1:0] cmd_q;
	logic [asa_pkg::ID_W-1:0]  idx_q;
	logic                      bad_q;
	logic [DW-1:0]             w_q, h_q;
	logic                      lock_q;

	// Sequencer registers
	logic [IW-1:0]   scan_q, scan_n;
	logic [IW-1:0]   tgt_q, tgt_n;
	logic [IW-1:0]   free_idx_q, free_idx_n;
	logic            free_found_q, free_found_n;
	asa_pkg::res_t   res_q, res_n;
	logic            out_valid_q;
	asa_pkg::res_t   out_q;

	// Page table and fit unit hookup
	logic [IW-1:0]   rd_idx, wr_idx;
	logic            tbl_we;
	asa_pkg::entry_t rd_entry, wr_entry, place_entry;
	asa_pkg::fit_t   fit;
	asa_pkg::res_t   place_res;

	logic [UW-1:0]   users_inc, users_dec;
	logic [DW-1:0]   open_w, open_h, eff_w, eff_h;
	logic            free_now, last_scan, out_free;

	function automatic logic dim_ok(input logic [DW-1:0] w, input logic [DW-1:0] h);
		logic ok;
		ok = (w != '0) && (h != '0) && (w <= DW'(asa_pkg::MAX_DIM)) &&
		     (h <= DW'(asa_pkg::MAX_DIM));
		return ok;
	endfunction

	asa_page_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_idx   (rd_idx),
		.rd_entry (rd_entry),
		.wr_en    (tbl_we),
		.wr_idx   (wr_idx),
		.wr_entry (wr_entry)
	);

	asa_fit_unit u_fit (
		.entry  (rd_entry),
		.rect_w (w_q),
		.rect_h (h_q),
		.margin (margin_q),
		.max_w  (max_w_q),
		.max_h  (max_h_q),
		.result (fit)
	);

	// Accept a beat only while idle; a queued result does not hold off the next command.
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// Read the scanned page during the scan, the target page otherwise.
	assign rd_idx = (state_q == S_SCAN) ? scan_q : tgt_q;
	assign wr_idx = (state_q == S_OPEN) ? free_idx_q : tgt_q;

	assign users_inc = (rd_entry.users == {UW{1'b1}}) ? rd_entry.users : rd_entry.users + 1'b1;
	assign users_dec = (rd_entry.users == '0) ? '0 : rd_entry.users - 1'b1;

	assign free_now  = free_found_q || !rd_entry.valid;
	assign last_scan = (scan_q == IW'(asa_pkg::PAGES - 1));

	// New page size: the rectangle for create, the default grown to the rectangle otherwise.
	always_comb begin
		if (cmd_q == asa_pkg::CMD_CREATE) begin
			open_w = w_q;
			open_h = h_q;
			eff_w  = '0;
			eff_h  = '0;
		end else begin
			open_w = (w_q > max_w_q) ? w_q : max_w_q;
			open_h = (h_q > max_h_q) ? h_q : max_h_q;
			eff_w  = w_q;
			eff_h  = h_q;
		end
	end

	// Placement of the rectangle on the target page, shared by both insert commands.
	always_comb begin
		place_entry       = rd_entry;
		place_entry.cur_x = fit.cur_x;
		place_entry.cur_y = fit.pos_y;
		place_entry.shelf = fit.shelf;
		place_entry.users = users_inc;

		place_res         = '0;
		place_res.status  = asa_pkg::ST_OK;
		place_res.page_id = asa_pkg::ID_W'(tgt_q);
		place_res.pos_x   = fit.pos_x;
		place_res.pos_y   = fit.pos_y;
		place_res.pw      = rd_entry.w;
		place_res.ph      = rd_entry.h;
		place_res.users   = users_inc;
	end

	always_comb begin
		state_n      = state_q;
		scan_n       = scan_q;
		tgt_n        = tgt_q;
		free_idx_n   = free_idx_q;
		free_found_n = free_found_q;
		res_n        = res_q;
		tbl_we       = 1'b0;
		wr_entry     = rd_entry;

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					res_n        = '0;
					scan_n       = '0;
					free_found_n = 1'b0;
					tgt_n        = IW'(page_index);
					case (command)
						asa_pkg::CMD_INSERT_ANY, asa_pkg::CMD_CREATE: begin
							state_n = S_SCAN;
						end
						asa_pkg::CMD_INSERT_PAGE, asa_pkg::CMD_ADD_USER,
						asa_pkg::CMD_REMOVE_USER, asa_pkg::CMD_RESIZE: begin
							state_n = S_UPDATE;
						end
						default: begin
							// Unknown command: report a bad page, touch nothing.
							res_n.status = asa_pkg::ST_BAD_PAGE;
							state_n      = S_DONE;
						end
					endcase
				end
			end

			S_SCAN: begin
				if (cmd_q == asa_pkg::CMD_INSERT_ANY && rd_entry.valid && !rd_entry.locked &&
				    fit.fit) begin
					tgt_n   = scan_q;
					state_n = S_PLACE;
				end else begin
					if (!free_found_q) begin
						free_idx_n = scan_q;
					end
					free_found_n = free_now;
					// Create needs only a free slot; stop at the first one.
					if ((cmd_q == asa_pkg::CMD_CREATE && !rd_entry.valid) || last_scan) begin
						state_n = S_OPEN;
					end else begin
						scan_n = scan_q + 1'b1;
					end
				end
			end

			S_PLACE: begin
				tbl_we   = 1'b1;
				wr_entry = place_entry;
				res_n    = place_res;
				state_n  = S_DONE;
			end

			S_OPEN: begin
				state_n = S_DONE;
				if (!dim_ok(open_w, open_h)) begin
					res_n.status = asa_pkg::ST_NO_FIT;
				end else if (!free_found_q) begin
					res_n.status = asa_pkg::ST_FULL;
				end else begin
					tbl_we         = 1'b1;
					wr_entry       = '0;
					wr_entry.valid = 1'b1;
					wr_entry.locked = (cmd_q == asa_pkg::CMD_CREATE) && lock_q;
					wr_entry.w     = open_w;
					wr_entry.h     = open_h;
					wr_entry.cur_x = asa_pkg::sat_dim(asa_pkg::SUM_W'(eff_w) +
					                                  asa_pkg::SUM_W'(margin_q));
					wr_entry.shelf = asa_pkg::sat_dim(asa_pkg::SUM_W'(eff_h) +
					                                  asa_pkg::SUM_W'(margin_q));
					wr_entry.users = UW'(1);
					res_n.status   = asa_pkg::ST_OK;
					res_n.page_id  = asa_pkg::ID_W'(free_idx_q);
					res_n.pw       = open_w;
					res_n.ph       = open_h;
					res_n.users    = UW'(1);
				end
			end

			S_UPDATE: begin
				state_n       = S_DONE;
				res_n.page_id = idx_q;
				if (bad_q || !rd_entry.valid) begin
					res_n.status = asa_pkg::ST_BAD_PAGE;
				end else begin
					case (cmd_q)
						asa_pkg::CMD_INSERT_PAGE: begin
							// Lock is ignored when the page is named.
							if (fit.fit) begin
								tbl_we   = 1'b1;
								wr_entry = place_entry;
								res_n    = place_res;
							end else begin
								res_n.status = asa_pkg::ST_NO_FIT;
							end
						end
						asa_pkg::CMD_ADD_USER: begin
							tbl_we         = 1'b1;
							wr_entry.users = users_inc;
							res_n.pw       = rd_entry.w;
							res_n.ph       = rd_entry.h;
							res_n.users    = users_inc;
						end
						asa_pkg::CMD_REMOVE_USER: begin
							tbl_we = 1'b1;
							if (users_dec == '0) begin
								// Last user gone: free the page, report size zero.
								wr_entry = '0;
							end else begin
								wr_entry.users = users_dec;
								res_n.pw       = rd_entry.w;
								res_n.ph       = rd_entry.h;
								res_n.users    = users_dec;
							end
						end
						asa_pkg::CMD_RESIZE: begin
							if (rd_entry.w == w_q && rd_entry.h == h_q) begin
								res_n.pw    = rd_entry.w;
								res_n.ph    = rd_entry.h;
								res_n.users = rd_entry.users;
							end else if (!dim_ok(w_q, h_q)) begin
								res_n.status = asa_pkg::ST_NO_FIT;
							end else begin
								// Keep the cursors; only the size changes.
								tbl_we      = 1'b1;
								wr_entry.w  = w_q;
								wr_entry.h  = h_q;
								res_n.pw    = w_q;
								res_n.ph    = h_q;
								res_n.users = rd_entry.users;
							end
						end
						default: begin
							res_n.status = asa_pkg::ST_BAD_PAGE;
						end
					endcase
				end
			end

			S_DONE: begin
				// Hold the result until the output register is free.
				if (out_free) begin
					state_n = S_IDLE;
				end
			end

			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			max_w_q      <= DW'(asa_pkg::DEFAULT_DIM);
			max_h_q      <= DW'(asa_pkg::DEFAULT_DIM);
			margin_q     <= '0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_n;
			free_found_q <= free_found_n;
			if (cfg_we) begin
				case (cfg_index)
					asa_pkg::CFG_MAX_W:  max_w_q  <= cfg_data;
					asa_pkg::CFG_MAX_H:  max_h_q  <= cfg_data;
					asa_pkg::CFG_MARGIN: margin_q <= cfg_data[asa_pkg::MARGIN_W-1:0];
					default: ;
				endcase
			end
			// Drop the beat once taken, then load a fresh one if one is waiting.
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_q     <= scan_n;
		tgt_q      <= tgt_n;
		free_idx_q <= free_idx_n;
		res_q      <= res_n;
		if (state_q == S_IDLE && in_valid) begin
			cmd_q  <= command;
			idx_q  <= page_index;
			bad_q  <= (32'(page_index) >= asa_pkg::PAGES);
			w_q    <= rect_width;
			h_q    <= rect_height;
			lock_q <= lock_page;
		end
		if (state_q == S_DONE && out_free) begin
			out_q <= res_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign page_id     = out_q.page_id;
	assign pos_x       = out_q.pos_x;
	assign pos_y       = out_q.pos_y;
	assign page_width  = out_q.pw;
	assign page_height = out_q.ph;
	assign user_count  = out_q.users;

	// An accepted beat always starts work.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != S_IDLE))
		else $error("accepted command did not leave idle");

	// A first-fit hit still fits when it is placed.
	a_place_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PLACE) |-> (rd_entry.valid && !rd_entry.locked && fit.fit))
		else $error("placement on a page that does not fit");

	// The page table changes only in the update steps.
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_we |-> (state_q == S_OPEN || state_q == S_UPDATE || state_q == S_PLACE))
		else $error("page table written outside an update step");

	// A finished result reaches the output register.
	a_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> (out_valid_q && state_q == S_IDLE))
		else $error("result not queued on completion");

endmodule
